### design/eblpq_pkg.sv
// Shared types and constants for the linear-predict quantizer.
`default_nettype none
package eblpq_pkg;

   localparam logic [63:0] Q_TWO    = 64'h0000_0002_0000_0000;
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [30:0] Q_LIMIT  = 31'h7FFF_FFFF;

   typedef enum logic {
      OP_DIV,
      OP_MUL
   } eblpq_op_type;

   typedef enum logic {
      REQ_ADD,
      REQ_CLOSE
   } eblpq_req_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLOSE_OUT,
      S_HDR_SIZE,
      S_HDR_BOUND,
      S_HDR_STAMP,
      S_DELTA_OUT,
      S_DIFF,
      S_CHOOSE,
      S_VEL_DIV,
      S_VEL_RND,
      S_EXT_WAIT,
      S_EXT_ADD,
      S_Q_SUB,
      S_Q_DIV,
      S_Q_RND,
      S_R_WAIT,
      S_R_ADD,
      S_CODE_OUT
   } eblpq_state_type;

   typedef struct packed {
      logic         start;
      eblpq_op_type op;
   } eblpq_cmd_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } eblpq_sts_type;

endpackage
`default_nettype wire

### design/eblpq_serial_unit.sv
// Shared bit-serial 64-bit divider and multiplier, one bit per cycle.
`default_nettype none
module eblpq_serial_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire eblpq_pkg::eblpq_cmd_type cmd,
   input  wire logic [63:0]          opa,
   input  wire logic [63:0]          opb,
   output eblpq_pkg::eblpq_sts_type  sts,
   output logic [63:0]               result,
   output logic [63:0]               remainder
);
   import eblpq_pkg::*;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic         ovf_ff, ovf_in;
   logic [5:0]   count_ff, count_in;
   eblpq_op_type op_ff, op_in;
   logic [63:0]  num_ff, num_in;
   logic [63:0]  acc_ff, acc_in;
   logic [63:0]  den_ff, den_in;

   logic [65:0]  addend_x;
   logic [65:0]  addend_y;
   logic [65:0]  sum;
   logic         ge;

   // one shared 66-bit adder: trial subtract for divide, add for multiply
   always_comb begin
      addend_x = {1'b0, acc_ff, (op_ff == OP_DIV) ? num_ff[63] : 1'b0};
      if (op_ff == OP_DIV) begin
         addend_y = ~{2'b00, den_ff} + 66'd1;
      end else begin
         addend_y = num_ff[63] ? {2'b00, den_ff} : 66'd0;
      end
      sum = addend_x + addend_y;
      ge  = ~sum[65];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      op_in    = op_ff;
      num_in   = num_ff;
      acc_in   = acc_ff;
      den_in   = den_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         ovf_in   = 1'b0;
         count_in = '0;
         op_in    = cmd.op;
         num_in   = opa;
         acc_in   = '0;
         den_in   = opb;
      end else if (busy_ff) begin
         count_in = count_ff + 6'd1;
         num_in   = {num_ff[62:0], (op_ff == OP_DIV) ? ge : 1'b0};
         unique case (op_ff)
            OP_DIV: acc_in = ge ? sum[63:0] : addend_x[63:0];
            OP_MUL: begin
               acc_in = sum[63:0];
               ovf_in = ovf_ff | sum[65] | sum[64];
            end
            default: acc_in = acc_ff;
         endcase
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
         op_ff    <= OP_DIV;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
         op_ff    <= op_in;
      end
      ovf_ff <= ovf_in;
      num_ff <= num_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
   end

   // quotient collects in num for divide; product sits in acc for multiply
   assign result    = (op_ff == OP_DIV) ? num_ff : acc_ff;
   assign remainder = acc_ff;
   assign sts.done  = done_ff;
   assign sts.ovf   = ovf_ff;

endmodule
`default_nettype wire

### design/error_bounded_linear_predict_quantizer_unit.sv
// Top level of the error-bounded linear-predict quantizer with gamma coding.
// Close: accepted from idle; its single result is registered once the output is free.
// Add: the first or second sample of a block runs one divide and one multiply;
//   velocity extrapolation, when it runs, adds one more of each, and an output
//   stall holds the item; each 64-bit divide or multiply holds the one shared
//   bit-serial unit, and one item is in flight, so a new request waits until the last is through.
// Synchronous active-high reset clears control, registers and predictor state.
`default_nettype none
module error_bounded_linear_predict_quantizer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [63:0] req_sample,
   input  wire logic [63:0] req_stamp,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_chunk,
   output logic [6:0]       rsp_chunk_len,
   output logic             rsp_last,
   output logic [47:0]      rsp_total_bits,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import eblpq_pkg::*;

   localparam logic REG_BLOCK_SIZE  = 1'b0;
   localparam logic REG_ERROR_BOUND = 1'b1;

   // saturating add of a magnitude to a signed 64-bit pattern
   function automatic logic [63:0] sat_add(input logic [63:0] bits, input logic neg,
                                           input logic [63:0] mag);
      logic [64:0] u_sum;
      logic [63:0] u;
      logic [63:0] r;
      u = bits ^ SIGN_BIT;
      if (!neg) begin
         u_sum = {1'b0, u} + {1'b0, mag};
         r = u_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : u_sum[63:0];
      end else begin
         r = (u < mag) ? 64'd0 : u - mag;
      end
      return r ^ SIGN_BIT;
   endfunction

   function automatic logic [5:0] bit_count(input logic [31:0] n);
      logic [5:0] b;
      b = '0;
      for (int i = 0; i < 32; i++) begin
         if (n[i]) begin
            b = 6'(i + 1);
         end
      end
      return b;
   endfunction

   // ---- configuration registers ----
   logic [31:0] block_size_ff;
   logic [31:0] bound_ff;
   logic        cfg_write;

   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= '0;
         bound_ff      <= 32'd65536;
      end else if (cfg_write) begin
         unique case (paddr[2])
            REG_BLOCK_SIZE:  block_size_ff <= pwdata;
            REG_ERROR_BOUND: bound_ff      <= pwdata;
            default:         block_size_ff <= block_size_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_BLOCK_SIZE:  prdata = block_size_ff;
         REG_ERROR_BOUND: prdata = bound_ff;
         default:         prdata = '0;
      endcase
   end

   // quantizer step is twice the bound; a zero bound acts as one
   logic [32:0] step;
   assign step = {((bound_ff == 32'd0) ? 32'd1 : bound_ff), 1'b0};

   // ---- state ----
   eblpq_state_type state_ff, state_in;
   logic        is_first_ff, is_first_in;
   logic        is_second_ff, is_second_in;
   logic [63:0] recon_last_ff, recon_last_in;
   logic [63:0] recon_before_ff, recon_before_in;
   logic [63:0] stamp_last_ff, stamp_last_in;
   logic [63:0] stamp_before_ff, stamp_before_in;
   logic [47:0] bit_total_ff, bit_total_in;

   logic [63:0] sample_ff, sample_in;
   logic [63:0] stamp_ff, stamp_in;
   logic        diff_neg_ff, diff_neg_in;
   logic [63:0] diff_mag_ff, diff_mag_in;
   logic [63:0] dt1_ff, dt1_in;
   logic [63:0] dt2_ff, dt2_in;
   logic [63:0] pred_ff, pred_in;
   logic        qneg_ff, qneg_in;
   logic [30:0] qm_ff, qm_in;
   logic [63:0] recon_new_ff, recon_new_in;
   logic [31:0] code_ff, code_in;
   logic [6:0]  code_len_ff, code_len_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_chunk_ff, rsp_chunk_in;
   logic [6:0]  rsp_len_ff, rsp_len_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [47:0] rsp_total_ff, rsp_total_in;

   // shared serial unit
   eblpq_cmd_type unit_cmd;
   eblpq_sts_type unit_sts;
   logic [63:0]   unit_a;
   logic [63:0]   unit_b;
   logic [63:0]   unit_result;
   logic [63:0]   unit_rem;

   eblpq_serial_unit u_serial (
      .clock     (clock),
      .reset     (reset),
      .cmd       (unit_cmd),
      .opa       (unit_a),
      .opb       (unit_b),
      .sts       (unit_sts),
      .result    (unit_result),
      .remainder (unit_rem)
   );

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // scratch terms for the combinational block
   logic [63:0] ua, ub;
   logic [63:0] ext;
   logic [63:0] qfull;
   logic        round_up;
   logic [63:0] dstep;
   logic        vel_ok;

   always_comb begin
      state_in        = state_ff;
      is_first_in     = is_first_ff;
      is_second_in    = is_second_ff;
      recon_last_in   = recon_last_ff;
      recon_before_in = recon_before_ff;
      stamp_last_in   = stamp_last_ff;
      stamp_before_in = stamp_before_ff;
      bit_total_in    = bit_total_ff;
      sample_in       = sample_ff;
      stamp_in        = stamp_ff;
      diff_neg_in     = diff_neg_ff;
      diff_mag_in     = diff_mag_ff;
      dt1_in          = dt1_ff;
      dt2_in          = dt2_ff;
      pred_in         = pred_ff;
      qneg_in         = qneg_ff;
      qm_in           = qm_ff;
      recon_new_in    = recon_new_ff;
      code_in         = code_ff;
      code_len_in     = code_len_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_chunk_in    = rsp_chunk_ff;
      rsp_len_in      = rsp_len_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_total_in    = rsp_total_ff;
      unit_cmd.start  = 1'b0;
      unit_cmd.op     = OP_DIV;
      unit_a          = diff_mag_ff;
      unit_b          = dt1_ff;
      ua              = '0;
      ub              = '0;
      ext             = '0;
      qfull           = '0;
      round_up        = 1'b0;
      dstep           = {31'd0, step};
      vel_ok          = 1'b0;
      req_stall       = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               stamp_in  = req_stamp;
               priority if (req_opcode == REQ_CLOSE) begin
                  state_in = S_CLOSE_OUT;
               end else if (is_first_ff) begin
                  state_in = S_HDR_SIZE;
               end else begin
                  state_in = S_DELTA_OUT;
               end
            end
         end

         // report the block total, then drop the predictor back to reset
         S_CLOSE_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_chunk_in    = '0;
               rsp_len_in      = '0;
               rsp_last_in     = 1'b1;
               rsp_total_in    = bit_total_ff;
               is_first_in     = 1'b1;
               is_second_in    = 1'b1;
               recon_last_in   = Q_TWO;
               recon_before_in = Q_TWO;
               stamp_last_in   = '0;
               stamp_before_in = '0;
               bit_total_in    = '0;
               state_in        = S_IDLE;
            end
         end

         S_HDR_SIZE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chunk_in = {32'd0, block_size_ff};
               rsp_len_in   = 7'd32;
               rsp_last_in  = 1'b0;
               rsp_total_in = '0;
               bit_total_in = bit_total_ff + 48'd32;
               state_in     = S_HDR_BOUND;
            end
         end

         S_HDR_BOUND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chunk_in = {32'd0, bound_ff};
               rsp_len_in   = 7'd64;
               rsp_last_in  = 1'b0;
               rsp_total_in = '0;
               bit_total_in = bit_total_ff + 48'd64;
               state_in     = S_HDR_STAMP;
            end
         end

         S_HDR_STAMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chunk_in = stamp_ff;
               rsp_len_in   = 7'd64;
               rsp_last_in  = 1'b0;
               rsp_total_in = '0;
               bit_total_in = bit_total_ff + 48'd64;
               pred_in      = Q_TWO;
               state_in     = S_Q_SUB;
            end
         end

         S_DELTA_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chunk_in = stamp_ff - stamp_last_ff;
               rsp_len_in   = 7'd64;
               rsp_last_in  = 1'b0;
               rsp_total_in = '0;
               bit_total_in = bit_total_ff + 48'd64;
               if (is_second_ff) begin
                  pred_in  = recon_last_ff;
                  state_in = S_Q_SUB;
               end else begin
                  state_in = S_DIFF;
               end
            end
         end

         // slope numerator and the two time deltas
         S_DIFF: begin
            ua = recon_last_ff ^ SIGN_BIT;
            ub = recon_before_ff ^ SIGN_BIT;
            diff_neg_in = (ua < ub);
            diff_mag_in = (ua < ub) ? ub - ua : ua - ub;
            dt1_in      = stamp_last_ff - stamp_before_ff;
            dt2_in      = stamp_ff - stamp_last_ff;
            state_in    = S_CHOOSE;
         end

         S_CHOOSE: begin
            vel_ok = (stamp_ff != 64'd0) && (stamp_last_ff != 64'd0) &&
                     (stamp_before_ff != 64'd0) &&
                     (dt1_ff != 64'd0) && !dt1_ff[63] &&
                     (dt2_ff != 64'd0) && !dt2_ff[63];
            if (vel_ok) begin
               unit_cmd.start = 1'b1;
               unit_cmd.op    = OP_DIV;
               unit_a         = diff_mag_ff;
               unit_b         = dt1_ff;
               state_in       = S_VEL_DIV;
            end else begin
               pred_in  = sat_add(recon_last_ff, diff_neg_ff, diff_mag_ff);
               state_in = S_Q_SUB;
            end
         end

         S_VEL_DIV: begin
            if (unit_sts.done) begin
               state_in = S_VEL_RND;
            end
         end

         // round the velocity half away, then scale it by the new delta
         S_VEL_RND: begin
            round_up = (unit_rem != 64'd0) && (unit_rem >= dt1_ff - unit_rem);
            unit_cmd.start = 1'b1;
            unit_cmd.op    = OP_MUL;
            unit_a         = unit_result + {63'd0, round_up};
            unit_b         = dt2_ff;
            state_in       = S_EXT_WAIT;
         end

         S_EXT_WAIT: begin
            if (unit_sts.done) begin
               state_in = S_EXT_ADD;
            end
         end

         S_EXT_ADD: begin
            ext      = unit_sts.ovf ? 64'hFFFF_FFFF_FFFF_FFFF : unit_result;
            pred_in  = sat_add(recon_last_ff, diff_neg_ff, ext);
            state_in = S_Q_SUB;
         end

         // residual against the prediction, divided by the step
         S_Q_SUB: begin
            ua = sample_ff ^ SIGN_BIT;
            ub = pred_ff ^ SIGN_BIT;
            qneg_in        = (ua < ub);
            unit_cmd.start = 1'b1;
            unit_cmd.op    = OP_DIV;
            unit_a         = (ua < ub) ? ub - ua : ua - ub;
            unit_b         = dstep;
            state_in       = S_Q_DIV;
         end

         S_Q_DIV: begin
            if (unit_sts.done) begin
               state_in = S_Q_RND;
            end
         end

         S_Q_RND: begin
            round_up = (unit_rem != 64'd0) && (unit_rem >= dstep - unit_rem);
            qfull    = unit_result + {63'd0, round_up};
            qm_in    = (qfull > {33'd0, Q_LIMIT}) ? Q_LIMIT : qfull[30:0];
            qneg_in  = qneg_ff && (qfull != 64'd0);
            unit_cmd.start = 1'b1;
            unit_cmd.op    = OP_MUL;
            unit_a         = {33'd0, qm_in};
            unit_b         = dstep;
            state_in       = S_R_WAIT;
         end

         S_R_WAIT: begin
            if (unit_sts.done) begin
               state_in = S_R_ADD;
            end
         end

         // reconstruction and zigzag code with its gamma length
         S_R_ADD: begin
            recon_new_in = sat_add(pred_ff, qneg_ff, unit_result);
            code_in      = qneg_ff ? {qm_ff, 1'b0} : {qm_ff, 1'b1};
            code_len_in  = {bit_count(code_in), 1'b0} - 7'd1;
            state_in     = S_CODE_OUT;
         end

         S_CODE_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_chunk_in  = {32'd0, code_ff};
               rsp_len_in    = code_len_ff;
               rsp_last_in   = 1'b1;
               rsp_total_in  = '0;
               bit_total_in  = bit_total_ff + {41'd0, code_len_ff};
               if (is_first_ff) begin
                  is_first_in = 1'b0;
               end else begin
                  is_second_in    = 1'b0;
                  recon_before_in = recon_last_ff;
                  stamp_before_in = stamp_last_ff;
               end
               recon_last_in = recon_new_ff;
               stamp_last_in = stamp_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         is_first_ff     <= 1'b1;
         is_second_ff    <= 1'b1;
         recon_last_ff   <= Q_TWO;
         recon_before_ff <= Q_TWO;
         stamp_last_ff   <= '0;
         stamp_before_ff <= '0;
         bit_total_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         is_first_ff     <= is_first_in;
         is_second_ff    <= is_second_in;
         recon_last_ff   <= recon_last_in;
         recon_before_ff <= recon_before_in;
         stamp_last_ff   <= stamp_last_in;
         stamp_before_ff <= stamp_before_in;
         bit_total_ff    <= bit_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      stamp_ff     <= stamp_in;
      diff_neg_ff  <= diff_neg_in;
      diff_mag_ff  <= diff_mag_in;
      dt1_ff       <= dt1_in;
      dt2_ff       <= dt2_in;
      pred_ff      <= pred_in;
      qneg_ff      <= qneg_in;
      qm_ff        <= qm_in;
      recon_new_ff <= recon_new_in;
      code_ff      <= code_in;
      code_len_ff  <= code_len_in;
      rsp_chunk_ff <= rsp_chunk_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chunk      = rsp_chunk_ff;
   assign rsp_chunk_len  = rsp_len_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_total_bits = rsp_total_ff;

   // one transaction in flight: intake closes right after an accept
   a_intake_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("intake open after accept");

   a_total_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_total_bits == 48'd0))
      else $error("total reported on non-final transaction");

   a_unit_done_waited: assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> (state_ff == S_VEL_DIV || state_ff == S_EXT_WAIT ||
                         state_ff == S_Q_DIV || state_ff == S_R_WAIT))
      else $error("serial unit finished outside a wait state");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLOSE_OUT && out_free) |=> (bit_total_ff == 48'd0 && is_first_ff))
      else $error("close did not clear the block");

endmodule
`default_nettype wire
